// ----- rtl/core/slt_pkg.sv -----
// Package for the sorted key table: shared widths, operation codes,
// sequencer states and the compare unit's result type. No dependencies.
package slt_pkg;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned DEPTH_DEF = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT  = 2'd0,
		KIND_REMOVE  = 2'd1,
		KIND_RESTART = 2'd2,
		KIND_NEXT    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_REM_RD,
		ST_REM_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_NXT_DAT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic less;   // stored key below search key (signed)
		logic equal;
	} cmp_res_t;

endpackage

// ----- rtl/core/slt_if.sv -----
// Valid/ready channel interfaces for the sorted key table.
// Depends on slt_pkg for the key and kind widths.
interface slt_req_if;
	logic                                valid;
	logic                                ready;
	logic [slt_pkg::KIND_W-1:0]          kind;
	logic signed [slt_pkg::KEY_W-1:0]    key_value;

	modport source (output valid, kind, key_value, input ready);
	modport sink   (input valid, kind, key_value, output ready);
endinterface

interface slt_rsp_if #(
	parameter int unsigned CNT_W = 5
);
	logic                                valid;
	logic                                ready;
	logic                                done_ok;
	logic                                item_valid;
	logic signed [slt_pkg::KEY_W-1:0]    item_value;
	logic [CNT_W-1:0]                    entry_count;

	modport source (output valid, done_ok, item_valid, item_value, entry_count, input ready);
	modport sink   (input valid, done_ok, item_valid, item_value, entry_count, output ready);
endinterface

// ----- rtl/core/slt_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module slt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/slt_cmp.sv -----
// Shared key compare unit: signed less-than and equality of a stored key
// against the search key. Depends on slt_pkg.
module slt_cmp (
	input  logic signed [slt_pkg::KEY_W-1:0] stored,
	input  logic signed [slt_pkg::KEY_W-1:0] search,
	output slt_pkg::cmp_res_t                res
);

	always_comb begin
		res.less  = (stored < search);
		res.equal = (stored == search);
	end

endmodule

// ----- rtl/core/slt_ctrl.sv -----
// Sequencer for the sorted key table: scans and shifts the key RAM one
// entry at a time, holds count and iterator, drives the response register.
// Depends on slt_pkg and slt_if.
module slt_ctrl #(
	parameter int unsigned DEPTH  = slt_pkg::DEPTH_DEF,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	slt_req_if.sink                          req,
	slt_rsp_if.source                        rsp,
	output logic                             mem_we,
	output logic [AW-1:0]                    mem_waddr,
	output logic signed [slt_pkg::KEY_W-1:0] mem_wdata,
	output logic                             mem_re,
	output logic [AW-1:0]                    mem_raddr,
	input  logic signed [slt_pkg::KEY_W-1:0] mem_rdata,
	input  slt_pkg::cmp_res_t                cmp,
	output logic signed [slt_pkg::KEY_W-1:0] key
);

	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	slt_pkg::state_t state_q, state_n;

	logic signed [slt_pkg::KEY_W-1:0] key_q, key_n;
	logic [CNT_W-1:0] idx_q, idx_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [CNT_W-1:0] iter_q, iter_n;
	logic             res_ok_q, res_ok_n;
	logic             res_valid_q, res_valid_n;
	logic signed [slt_pkg::KEY_W-1:0] res_value_q, res_value_n;
	logic [CNT_W-1:0] idx_inc;
	logic             rsp_load;

	logic             rsp_valid_q;
	logic             rsp_ok_q;
	logic             rsp_item_valid_q;
	logic signed [slt_pkg::KEY_W-1:0] rsp_value_q;
	logic [CNT_W-1:0] rsp_count_q;

	assign idx_inc = idx_q + 1'b1;
	assign key     = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slt_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		key_n       = key_q;
		idx_n       = idx_q;
		count_n     = count_q;
		iter_n      = iter_q;
		res_ok_n    = res_ok_q;
		res_valid_n = res_valid_q;
		res_value_n = res_value_q;
		req.ready   = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = idx_q[AW-1:0];
		mem_wdata   = key_q;
		mem_re      = 1'b0;
		mem_raddr   = idx_q[AW-1:0];
		rsp_load    = 1'b0;

		case (state_q)
			slt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					key_n       = req.key_value;
					res_ok_n    = 1'b0;
					res_valid_n = 1'b0;
					res_value_n = '0;
					case (slt_pkg::kind_t'(req.kind))
						slt_pkg::KIND_INSERT: begin
							idx_n   = count_q;
							state_n = (count_q == FULL) ? slt_pkg::ST_RESP
							                            : slt_pkg::ST_INS_RD;
						end
						slt_pkg::KIND_REMOVE: begin
							idx_n   = '0;
							state_n = slt_pkg::ST_REM_RD;
						end
						slt_pkg::KIND_RESTART: begin
							iter_n  = '0;
							state_n = slt_pkg::ST_RESP;
						end
						slt_pkg::KIND_NEXT: begin
							if (iter_q < count_q) begin
								mem_re    = 1'b1;
								mem_raddr = iter_q[AW-1:0];
								state_n   = slt_pkg::ST_NXT_DAT;
							end else begin
								state_n = slt_pkg::ST_RESP;
							end
						end
						default: state_n = slt_pkg::ST_RESP;
					endcase
				end
			end
			// insert walks down from the tail, moving smaller keys up by one
			slt_pkg::ST_INS_RD: begin
				if (idx_q == '0) begin
					mem_we   = 1'b1;
					count_n  = count_q + 1'b1;
					res_ok_n = 1'b1;
					state_n  = slt_pkg::ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_n[AW-1:0] - 1'b1;
					state_n   = slt_pkg::ST_INS_CMP;
				end
			end
			slt_pkg::ST_INS_CMP: begin
				mem_we = 1'b1;
				if (cmp.less) begin
					mem_wdata = mem_rdata;
					idx_n     = idx_q - 1'b1;
					state_n   = slt_pkg::ST_INS_RD;
				end else begin
					count_n  = count_q + 1'b1;
					res_ok_n = 1'b1;
					state_n  = slt_pkg::ST_RESP;
				end
			end
			slt_pkg::ST_REM_RD: begin
				if (idx_q == count_q) begin
					state_n = slt_pkg::ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_n = slt_pkg::ST_REM_CMP;
				end
			end
			slt_pkg::ST_REM_CMP: begin
				if (cmp.equal) begin
					res_ok_n = 1'b1;
					state_n  = slt_pkg::ST_SH_RD;
				end else begin
					idx_n   = idx_inc;
					state_n = slt_pkg::ST_REM_RD;
				end
			end
			// close the gap: entry idx takes entry idx+1
			slt_pkg::ST_SH_RD: begin
				if (idx_inc >= count_q) begin
					count_n = count_q - 1'b1;
					state_n = slt_pkg::ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_inc[AW-1:0];
					state_n   = slt_pkg::ST_SH_WR;
				end
			end
			slt_pkg::ST_SH_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				idx_n     = idx_inc;
				state_n   = slt_pkg::ST_SH_RD;
			end
			slt_pkg::ST_NXT_DAT: begin
				res_valid_n = 1'b1;
				res_value_n = mem_rdata;
				iter_n      = iter_q + 1'b1;
				state_n     = slt_pkg::ST_RESP;
			end
			slt_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_n  = slt_pkg::ST_IDLE;
				end
			end
			default: state_n = slt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			iter_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_n;
			iter_q  <= iter_n;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q       <= key_n;
		idx_q       <= idx_n;
		res_ok_q    <= res_ok_n;
		res_valid_q <= res_valid_n;
		res_value_q <= res_value_n;
		if (rsp_load) begin
			rsp_ok_q         <= res_ok_q;
			rsp_item_valid_q <= res_valid_q;
			rsp_value_q      <= res_value_q;
			rsp_count_q      <= count_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.done_ok     = rsp_ok_q;
	assign rsp.item_valid  = rsp_item_valid_q;
	assign rsp.item_value  = rsp_value_q;
	assign rsp.entry_count = rsp_count_q;

endmodule

// ----- rtl/core/sorted_list_table.sv -----
// Sorted key table: up to DEPTH signed 32-bit keys held in descending order.
// Depends on slt_pkg, slt_if, slt_ram, slt_cmp and slt_ctrl.
//
// req channel: kind (insert, remove, restart iteration, next item) and
// key_value. rsp channel: one transfer per request with done_ok, item_valid,
// item_value and entry_count (keys held after the request).
// One request is worked at a time; req.ready is high only while idle.
// Work per request: insert reads and compares each smaller key from the tail
// and moves it up by one (one RAM read and compare per key moved), and goes
// straight to the response when the table is full; remove visits every held
// key, whether found or not; next item reads one entry; restart and a next
// item at the end of iteration use no RAM access.
// The request times are set by the single RAM port pair and the one shared
// compare unit, each key visited costing a read and a compare or write step.
// A finished response sits in an output register; if the receiver stalls,
// the next request is still taken and worked, then waits for the register.
// Reset clears the key count, the iterator and the response valid; the key
// RAM is not cleared, only entries below the count are ever read.
module sorted_list_table #(
	parameter int unsigned DEPTH  = slt_pkg::DEPTH_DEF,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic      clk,
	input  logic      arst_n,
	slt_req_if.sink   req,
	slt_rsp_if.source rsp
);

	logic                             mem_we;
	logic [AW-1:0]                    mem_waddr;
	logic signed [slt_pkg::KEY_W-1:0] mem_wdata;
	logic                             mem_re;
	logic [AW-1:0]                    mem_raddr;
	logic signed [slt_pkg::KEY_W-1:0] mem_rdata;
	logic signed [slt_pkg::KEY_W-1:0] search_key;
	slt_pkg::cmp_res_t                cmp_res;

	slt_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.cmp       (cmp_res),
		.key       (search_key)
	);

	slt_ram #(
		.WIDTH (slt_pkg::KEY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	slt_cmp u_cmp (
		.stored (mem_rdata),
		.search (search_key),
		.res    (cmp_res)
	);

	// the table is never written while waiting for a request
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !mem_we)
		else $error("key RAM written while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.entry_count <= DEPTH)
		else $error("entry count beyond table depth");

	a_item_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.item_valid |-> !rsp.done_ok)
		else $error("item returned together with done_ok");

	a_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.item_valid |-> rsp.item_value == '0)
		else $error("item value not zero without an item");

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for the sorted key table: drives inserts, removes and walks
// over the valid/ready channels and checks every response against a behavioural table.
// Depends on slt_pkg, slt_if and sorted_list_table.

localparam int unsigned CNT_W = $clog2(slt_pkg::DEPTH_DEF + 1);

typedef struct packed {
	logic                             done_ok;
	logic                             item_valid;
	logic signed [slt_pkg::KEY_W-1:0] item_value;
	logic [CNT_W-1:0]                 entry_count;
} table_rsp_t;

class key_table_sb;
	logic signed [slt_pkg::KEY_W-1:0] keys [slt_pkg::DEPTH_DEF];
	int unsigned                      held;
	int unsigned                      walk_pos;
	table_rsp_t                       expected_rsp [$];
	int unsigned                      fails;

	function new();
		held     = 0;
		walk_pos = 0;
		fails    = 0;
	endfunction

	// apply one accepted request to the table and queue the response it must give
	function void note_request(slt_pkg::kind_t op, logic signed [slt_pkg::KEY_W-1:0] key);
		table_rsp_t  r;
		int unsigned pos;
		int unsigned i;
		r   = '0;
		pos = 0;
		case (op)
		slt_pkg::KIND_INSERT: begin
			if (held < slt_pkg::DEPTH_DEF) begin
				// equal keys stay ahead of the new one
				while (pos < held && keys[pos] >= key)
					pos++;
				for (i = held; i > pos; i--)
					keys[i] = keys[i-1];
				keys[pos] = key;
				held++;
				r.done_ok = 1'b1;
			end
		end
		slt_pkg::KIND_REMOVE: begin
			while (pos < held && keys[pos] != key)
				pos++;
			if (pos < held) begin
				for (i = pos; i + 1 < held; i++)
					keys[i] = keys[i+1];
				held--;
				r.done_ok = 1'b1;
			end
		end
		slt_pkg::KIND_RESTART: walk_pos = 0;
		default: begin
			// walk index is not adjusted by table edits
			if (walk_pos < held) begin
				r.item_valid = 1'b1;
				r.item_value = keys[walk_pos];
				walk_pos++;
			end
		end
		endcase
		r.entry_count = CNT_W'(held);
		expected_rsp.push_back(r);
	endfunction

	function void field_check(string name, logic signed [slt_pkg::KEY_W-1:0] want,
			logic signed [slt_pkg::KEY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d (%h) got %0d (%h)", $time, name, want, want,
				got, got);
			fails++;
		end
	endfunction

	function void check_response(table_rsp_t got);
		table_rsp_t want;
		if (expected_rsp.size() == 0) begin
			$display("%0t: response transfer with none outstanding, got %h", $time, got);
			fails++;
			return;
		end
		want = expected_rsp.pop_front();
		field_check("done_ok", slt_pkg::KEY_W'(want.done_ok),
			slt_pkg::KEY_W'(got.done_ok));
		field_check("item_valid", slt_pkg::KEY_W'(want.item_valid),
			slt_pkg::KEY_W'(got.item_valid));
		field_check("item_value", want.item_value, got.item_value);
		field_check("entry_count", slt_pkg::KEY_W'(want.entry_count),
			slt_pkg::KEY_W'(got.entry_count));
	endfunction
endclass

module tb;
	localparam logic signed [slt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
	localparam logic signed [slt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

	logic         clk;
	logic         arst_n;
	logic         steady;
	int unsigned  sent;
	table_rsp_t   seen;
	key_table_sb  sb;

	slt_req_if                  req_ch ();
	slt_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

	sorted_list_table #(.DEPTH(slt_pkg::DEPTH_DEF)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// check before noting, so a stray response cannot pair with the request of the same edge
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			seen.done_ok     = rsp_ch.done_ok;
			seen.item_valid  = rsp_ch.item_valid;
			seen.item_value  = rsp_ch.item_value;
			seen.entry_count = rsp_ch.entry_count;
			sb.check_response(seen);
		end
		if (req_ch.valid && req_ch.ready)
			sb.note_request(slt_pkg::kind_t'(req_ch.kind), req_ch.key_value);
	end

	always @(negedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= 34);
	end

	task automatic send_request(slt_pkg::kind_t op, logic signed [slt_pkg::KEY_W-1:0] key);
		while (!steady && $urandom_range(99) < 34) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= op;
		req_ch.key_value <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// small values give duplicates, held keys give remove hits
	function automatic logic signed [slt_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(9))
		0, 1, 2, 3: return slt_pkg::KEY_W'(int'($urandom_range(8)) - 4);
		4, 5: begin
			if (sb.held > 0)
				return sb.keys[$urandom_range(sb.held - 1)];
			return $urandom;
		end
		6, 7: begin
			case ($urandom_range(4))
			0: return KEY_MAX;
			1: return KEY_MIN;
			2: return '0;
			3: return '1;
			default: return slt_pkg::KEY_W'(1) << $urandom_range(slt_pkg::KEY_W - 1);
			endcase
		end
		default: return $urandom;
		endcase
	endfunction

	initial begin
		sb                = new();
		steady            = 1'b0;
		sent              = 0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.kind       = slt_pkg::KIND_INSERT;
		req_ch.key_value  = '0;
		rsp_ch.ready      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table: walk end, restart, remove miss
		send_request(slt_pkg::KIND_NEXT, $urandom);
		send_request(slt_pkg::KIND_RESTART, $urandom);
		send_request(slt_pkg::KIND_REMOVE, 32'sd5);
		send_request(slt_pkg::KIND_INSERT, KEY_MAX);
		send_request(slt_pkg::KIND_INSERT, KEY_MIN);
		send_request(slt_pkg::KIND_INSERT, '0);
		send_request(slt_pkg::KIND_INSERT, '1);
		send_request(slt_pkg::KIND_INSERT, 32'sd1);
		send_request(slt_pkg::KIND_INSERT, '0);
		// full walk and one step past the end
		send_request(slt_pkg::KIND_RESTART, $urandom);
		repeat (7) send_request(slt_pkg::KIND_NEXT, $urandom);
		send_request(slt_pkg::KIND_REMOVE, KEY_MIN);
		send_request(slt_pkg::KIND_REMOVE, KEY_MAX);
		send_request(slt_pkg::KIND_REMOVE, 32'sd5);
		// edit the table in the middle of a walk
		send_request(slt_pkg::KIND_RESTART, $urandom);
		send_request(slt_pkg::KIND_NEXT, $urandom);
		send_request(slt_pkg::KIND_INSERT, 32'sd2);
		send_request(slt_pkg::KIND_NEXT, $urandom);

		while (sent < 1900) begin
			steady = (sent >= 700 && sent < 1000);
			case ($urandom_range(9))
			0, 1, 2: begin
				// fill past full
				repeat (slt_pkg::DEPTH_DEF - sb.held + $urandom_range(1, 3))
					send_request(slt_pkg::KIND_INSERT, pick_key());
			end
			3, 4: begin
				repeat (sb.held + $urandom_range(1, 2)) begin
					if (sb.held > 0 && $urandom_range(9) < 8)
						send_request(slt_pkg::KIND_REMOVE,
							sb.keys[$urandom_range(sb.held - 1)]);
					else
						send_request(slt_pkg::KIND_REMOVE, pick_key());
				end
			end
			5, 6, 7: begin
				send_request(slt_pkg::KIND_RESTART, $urandom);
				repeat (sb.held + $urandom_range(0, 2)) begin
					if ($urandom_range(9) == 0)
						send_request(slt_pkg::kind_t'($urandom_range(1)), pick_key());
					else
						send_request(slt_pkg::KIND_NEXT, $urandom);
				end
			end
			default: begin
				repeat (20)
					send_request(slt_pkg::kind_t'($urandom_range(3)), pick_key());
			end
			endcase
		end
		steady       = 1'b0;
		req_ch.valid <= 1'b0;

		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#6000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
